// ===== src/rsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, types and register codes of the ray to sphere distance unit.
package rsd_pkg;

	localparam int CoordW  = 32;
	localparam int DirW    = 18;
	localparam int RadW    = 31;
	localparam int TolW    = 32;
	localparam int DistW   = 40;
	localparam int CfgIdxW = 3;
	localparam int DiffW   = CoordW + 1;
	localparam int SqW     = 2 * DiffW - 1;
	localparam int CW      = 68;
	localparam int AbsCW   = CW - 1;
	localparam int BW      = 53;
	localparam int AbW     = BW - 1;
	localparam int HalfW   = AbW / 2;
	localparam int RadicW  = 2 * AbW;
	localparam int DiscW   = RadicW + 2;
	localparam int RootW   = AbW;
	localparam int NumW    = AbsCW + 32;
	localparam int MW      = AbW + 1;
	localparam int QBits   = 62;
	localparam int DivW    = MW + QBits;
	localparam int QW      = QBits + 1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_TOL      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic            b_neg;
		logic [AbW-1:0]  ab;
		logic            c_pos;
		logic            c_neg;
		logic            surf;
		logic            miss;
	} ray_info_t;

endpackage

// ===== src/ray_sphere_distance_unit.sv =====
`timescale 1ns / 1ps
// Top level: fully pipelined ray to sphere surface distance unit.
// The unit accepts one ray per clock and returns one result per ray, in order.
// Most of its stages lie in the square root, which resolves one root bit per
// stage over 52 stages, and in the divider for the root of smaller magnitude,
// which resolves one quotient bit per stage over 62 stages. The whole pipeline
// holds while a finished result is stalled at the output.
module ray_sphere_distance_unit import rsd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [CoordW-1:0] origin_x,
	input  logic signed [CoordW-1:0] origin_y,
	input  logic signed [CoordW-1:0] origin_z,
	input  logic signed [DirW-1:0]   dir_x,
	input  logic signed [DirW-1:0]   dir_y,
	input  logic signed [DirW-1:0]   dir_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic [DistW-1:0]         distance
);

	logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
	logic [RadW-1:0]          rad_q;
	logic [TolW-1:0]          tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			cz_q  <= '0;
			rad_q <= RadW'(65536);
			tol_q <= TolW'(4295);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X: cx_q  <= cfg_data;
				REG_CENTER_Y: cy_q  <= cfg_data;
				REG_CENTER_Z: cz_q  <= cfg_data;
				REG_RADIUS:   rad_q <= cfg_data[RadW-1:0];
				REG_TOL:      tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	logic v_out_s8;
	assign adv      = ~(v_out_s8 & out_stall);
	assign in_stall = ~adv;

	// Stage 1: offsets from the centre.
	logic                    v_s1;
	logic signed [DiffW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [DirW-1:0]  ux_s1, uy_s1, uz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DiffW'(origin_x) - DiffW'(cx_q);
			dy_s1 <= DiffW'(origin_y) - DiffW'(cy_q);
			dz_s1 <= DiffW'(origin_z) - DiffW'(cz_q);
			ux_s1 <= dir_x;
			uy_s1 <= dir_y;
			uz_s1 <= dir_z;
		end
	end

	// Stage 2: products.
	logic                         v_s2;
	logic [SqW-2:0]               sx_s2, sy_s2, sz_s2;
	logic [2*RadW-1:0]            r2_s2;
	logic signed [DiffW+DirW-1:0] bx_s2, by_s2, bz_s2;
	logic signed [2*DiffW-1:0]    px, py, pz;

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s2 <= px[SqW-2:0];
			sy_s2 <= py[SqW-2:0];
			sz_s2 <= pz[SqW-2:0];
			r2_s2 <= rad_q * rad_q;
			bx_s2 <= dx_s1 * ux_s1;
			by_s2 <= dy_s1 * uy_s1;
			bz_s2 <= dz_s1 * uz_s1;
		end
	end

	// Stage 3: C and B.
	logic                v_s3;
	logic signed [CW-1:0] c_s3;
	logic signed [BW-1:0] b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3 <= CW'(sx_s2) + CW'(sy_s2) + CW'(sz_s2) - CW'(r2_s2);
			b_s3 <= BW'(bx_s2) + BW'(by_s2) + BW'(bz_s2);
		end
	end

	// Stage 4: surface test and partial products of B squared.
	logic [AbsCW-1:0]     absc;
	logic [AbW-1:0]       ab;
	logic                 v_s4;
	logic signed [CW-1:0] c_s4;
	logic                 bneg_s4, surf_s4;
	logic [AbW-1:0]       ab_s4;
	logic [NumW-1:0]      num_s4;
	logic [2*HalfW-1:0]   pll_s4, plh_s4, phh_s4;

	assign absc = c_s3[CW-1] ? AbsCW'(-c_s3) : AbsCW'(c_s3);
	assign ab   = b_s3[BW-1] ? AbW'(-b_s3) : AbW'(b_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4    <= c_s3;
			bneg_s4 <= b_s3[BW-1];
			ab_s4   <= ab;
			surf_s4 <= absc < AbsCW'(tol_q);
			num_s4  <= {absc, 32'b0};
			pll_s4  <= ab[HalfW-1:0] * ab[HalfW-1:0];
			plh_s4  <= ab[HalfW-1:0] * ab[AbW-1:HalfW];
			phh_s4  <= ab[AbW-1:HalfW] * ab[AbW-1:HalfW];
		end
	end

	// Stage 5: B squared.
	logic                 v_s5;
	logic signed [CW-1:0] c_s5;
	logic                 bneg_s5, surf_s5;
	logic [AbW-1:0]       ab_s5;
	logic [NumW-1:0]      num_s5;
	logic [RadicW-1:0]    bsq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s5    <= c_s4;
			bneg_s5 <= bneg_s4;
			ab_s5   <= ab_s4;
			surf_s5 <= surf_s4;
			num_s5  <= num_s4;
			bsq_s5  <= (RadicW'(phh_s4) << (2 * HalfW)) + (RadicW'(plh_s4) << (HalfW + 1))
				+ RadicW'(pll_s4);
		end
	end

	// Stage 6: discriminant, which seeds the square root.
	logic signed [DiscW-1:0] disc;
	assign disc = DiscW'(bsq_s5) - (DiscW'(c_s5) <<< 32);

	logic                v_rt_sn    [0:RootW];
	logic [RadicW-1:0]   rem_rt_sn  [0:RootW];
	logic [RootW-1:0]    root_rt_sn [0:RootW];
	logic [NumW-1:0]     num_rt_sn  [0:RootW];
	ray_info_t           info_rt_sn [0:RootW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_rt_sn[0] <= 1'b0;
		else if (adv) v_rt_sn[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_rt_sn[0]        <= disc[RadicW-1:0];
			root_rt_sn[0]       <= '0;
			num_rt_sn[0]        <= num_s5;
			info_rt_sn[0].b_neg <= bneg_s5;
			info_rt_sn[0].ab    <= ab_s5;
			info_rt_sn[0].c_pos <= ~c_s5[CW-1] & (c_s5 != '0);
			info_rt_sn[0].c_neg <= c_s5[CW-1];
			info_rt_sn[0].surf  <= surf_s5;
			info_rt_sn[0].miss  <= disc[DiscW-1];
		end
	end

	// Square root, one bit per stage.
	for (genvar k = 0; k < RootW; k++) begin : g_root
		localparam int Bit = RootW - 1 - k;
		logic [RadicW-1:0] trial;
		logic              take;
		assign trial = (RadicW'(root_rt_sn[k]) << (Bit + 1)) + (RadicW'(1) << (2 * Bit));
		assign take  = rem_rt_sn[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_rt_sn[k+1] <= 1'b0;
			else if (adv) v_rt_sn[k+1] <= v_rt_sn[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_rt_sn[k+1]  <= take ? rem_rt_sn[k] - trial : rem_rt_sn[k];
				root_rt_sn[k+1] <= take ? root_rt_sn[k] | (RootW'(1) << Bit) : root_rt_sn[k];
				num_rt_sn[k+1]  <= num_rt_sn[k];
				info_rt_sn[k+1] <= info_rt_sn[k];
			end
		end
	end

	// Stage 7: divisor |B| + sqrt and the quotient cap test.
	logic [MW-1:0] msum;
	assign msum = MW'(info_rt_sn[RootW].ab) + MW'(root_rt_sn[RootW]);

	logic              v_dv_sn    [0:QBits];
	logic [NumW-1:0]   rem_dv_sn  [0:QBits];
	logic [QBits-1:0]  quot_dv_sn [0:QBits];
	logic [MW-1:0]     m_dv_sn    [0:QBits];
	logic              cap_dv_sn  [0:QBits];
	ray_info_t         info_dv_sn [0:QBits];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_dv_sn[0] <= 1'b0;
		else if (adv) v_dv_sn[0] <= v_rt_sn[RootW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_dv_sn[0]  <= num_rt_sn[RootW];
			quot_dv_sn[0] <= '0;
			m_dv_sn[0]    <= msum;
			cap_dv_sn[0]  <= MW'(num_rt_sn[RootW][NumW-1:QBits]) >= msum;
			info_dv_sn[0] <= info_rt_sn[RootW];
		end
	end

	// Restoring division, one quotient bit per stage.
	for (genvar j = 0; j < QBits; j++) begin : g_div
		localparam int Bit = QBits - 1 - j;
		logic [DivW-1:0] dv;
		logic            take;
		assign dv   = DivW'(m_dv_sn[j]) << Bit;
		assign take = DivW'(rem_dv_sn[j]) >= dv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dv_sn[j+1] <= 1'b0;
			else if (adv) v_dv_sn[j+1] <= v_dv_sn[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_dv_sn[j+1]  <= take ? rem_dv_sn[j] - dv[NumW-1:0] : rem_dv_sn[j];
				quot_dv_sn[j+1] <= take ? quot_dv_sn[j] | (QBits'(1) << Bit) : quot_dv_sn[j];
				m_dv_sn[j+1]    <= m_dv_sn[j];
				cap_dv_sn[j+1]  <= cap_dv_sn[j];
				info_dv_sn[j+1] <= info_dv_sn[j];
			end
		end
	end

	// Stage 8: root selection and output register.
	ray_info_t info_f;
	logic      hit_f;
	logic [DistW-1:0] dist_f;

	always_comb begin
		logic signed [63:0] qv, mv, sp, sm, dv;
		logic [47:0]        d16;
		info_f = info_dv_sn[QBits];
		qv     = cap_dv_sn[QBits] ? (64'sd1 <<< QBits) : 64'(quot_dv_sn[QBits]);
		mv     = 64'(m_dv_sn[QBits]);
		if (info_f.b_neg) begin
			sp = mv;
			sm = info_f.c_neg ? -qv : qv;
		end else begin
			sm = -mv;
			sp = (mv == 64'sd0) ? 64'sd0 : (info_f.c_neg ? qv : -qv);
		end
		hit_f = 1'b0;
		dv    = 64'sd0;
		if (info_f.surf) begin
			hit_f = 1'b1;
			dv    = info_f.b_neg ? 64'(info_f.ab) <<< 1 : 64'sd0;
		end else if (!info_f.miss) begin
			if (info_f.c_pos) begin
				if (sp > 64'sd0) begin
					hit_f = 1'b1;
					dv    = (sp < sm) ? sp : sm;
				end
			end else begin
				hit_f = 1'b1;
				dv    = (sp > 64'sd0) ? sp : sm;
			end
		end
		if (!hit_f || dv < 64'sd0) dv = 64'sd0;
		d16    = dv[63:16];
		dist_f = (d16 > 48'(DistW'('1))) ? DistW'('1) : d16[DistW-1:0];
	end

	logic             hit_s8;
	logic [DistW-1:0] dist_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_s8 <= 1'b0;
		else if (adv) v_out_s8 <= v_dv_sn[QBits];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s8  <= hit_f;
			dist_s8 <= dist_f;
		end
	end

	assign out_valid = v_out_s8;
	assign hit       = hit_s8;
	assign distance  = dist_s8;

endmodule
